### sv/ptw_pkg.sv
// Shared types, constants and helpers for the four-level page table walker.
// Used by ptw_ctrl, ptw_datapath and four_level_page_table_walker_core; no dependencies.
package ptw_pkg;

  // Default depth of the table memory in 64-bit words
  localparam int unsigned TableMemWordsDef = 4096;

  // Field widths
  localparam int unsigned VaW     = 64;
  localparam int unsigned VaUsedW = 48;
  localparam int unsigned WidxW   = 12;
  localparam int unsigned PteW    = 64;
  localparam int unsigned PaW     = 64;
  localparam int unsigned RootW   = 15;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned LevelW  = 2;

  // Stream packing: virt_addr, word_index, write_data, padded to whole bytes
  localparam int unsigned SDataRawW = VaW + WidxW + PteW;
  localparam int unsigned SDataW    = ((SDataRawW + 7) / 8) * 8;
  localparam int unsigned MDataW    = PaW;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = RootW;

  // Entry flag positions
  localparam int unsigned PresentBit = 0;
  localparam int unsigned HugeBit    = 7;

  // Walk levels with special meaning
  localparam logic [LevelW-1:0] LvlHuge = 2'd2;
  localparam logic [LevelW-1:0] LvlLeaf = 2'd3;

  // Request kinds carried in tuser
  localparam logic ReqWrite     = 1'b0;
  localparam logic ReqTranslate = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } ptw_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WALKER_ENABLED  = 1'b0,
    CFG_ROOT_TABLE_BASE = 1'b1
  } ptw_cfg_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic mem_write;     // store the accepted entry
    logic start;         // latch the virtual address of a new walk
    logic from_mem;      // evaluate the fetched entry (else root/input)
    logic issue_read;    // fetch the next entry, advance the level
    logic load_out;      // load the output register
    logic load_hold;     // park the result in the hold register
    logic out_from_hold; // output register takes the parked result
  } ptw_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic done;          // the walk ends in this cycle
  } ptw_status_t;

  // Pick the 9-bit table index for one level
  function automatic logic [IdxW-1:0] va_index(input logic [VaUsedW-1:0] va,
                                               input logic [LevelW-1:0] lvl);
    logic [IdxW-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      2'd3:    idx = va[20:12];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

### sv/four_level_page_table_walker_core.sv
// Top level of the four-level page table walker: stream ports and config port.
// Depends on ptw_pkg, ptw_ctrl and ptw_datapath.
//
//  Port group  Dir  Carries
//  s_axis_*    in   write item (tuser 0) or translate item (tuser 1)
//  m_axis_*    out  one result per translate: phys_addr in tdata, fault in tuser
//  cfg_*       in   register writes: 0 walker_enabled, 1 root_table_base
//
// A write item is stored as it is accepted. For a translate item, the accept cycle ends a
// disabled or out-of-memory walk or fetches the first-level entry, then each cycle
// checks one fetched entry and fetches the next, bound by the single table memory
// read port with its registered data. The last check loads the output register if free.
// Reset clears control state and configuration; the table memory is not cleared.
// A waiting result does not stop new items; a walk that ends while the output is full
// parks its result and holds input until it moves.
module four_level_page_table_walker_core
  import ptw_pkg::*;
#(
  parameter int unsigned TableMemWords = TableMemWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SDataW-1:0]   s_axis_tdata,  // virt_addr, word_index, write_data, zero pad
  input  logic                s_axis_tuser,  // req_type
  // Result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [MDataW-1:0]   m_axis_tdata,  // phys_addr
  output logic                m_axis_tuser,  // fault
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ptw_cmd_t    cmd;
  ptw_status_t status;

  logic [VaW-1:0]   virt_addr;
  logic [WidxW-1:0] word_index;
  logic [PteW-1:0]  write_data;

  // Unpack the input item
  assign virt_addr  = s_axis_tdata[VaW-1:0];
  assign word_index = s_axis_tdata[VaW+WidxW-1:VaW];
  assign write_data = s_axis_tdata[SDataRawW-1:VaW+WidxW];

  ptw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_req_type_i (s_axis_tuser),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ptw_datapath #(
    .TableMemWords (TableMemWords)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .virt_addr_i  (virt_addr),
    .word_index_i (word_index),
    .write_data_i (write_data),
    .cmd_i        (cmd),
    .status_o     (status),
    .phys_addr_o  (m_axis_tdata),
    .fault_o      (m_axis_tuser)
  );

endmodule

### sv/ptw_ctrl.sv
// Controller state machine of the page table walker: handshakes and walk sequencing.
// Depends on ptw_pkg; drives ptw_datapath through ptw_cmd_t.
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic        s_req_type_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  input  ptw_status_t status_i,
  output ptw_cmd_t    cmd_o
);

  ptw_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       s_hs;

  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign s_hs      = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_hs && (s_req_type_i == ReqTranslate)) begin
          if (!status_i.done) begin
            state_d = ST_WALK;
          end else if (!out_free) begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_WALK: begin
        if (status_i.done) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          if (s_req_type_i == ReqWrite) begin
            cmd_o.mem_write = 1'b1;
          end else begin
            cmd_o.start      = 1'b1;
            cmd_o.issue_read = !status_i.done;
            cmd_o.load_out   = status_i.done && out_free;
            cmd_o.load_hold  = status_i.done && !out_free;
          end
        end
      end
      ST_WALK: begin
        cmd_o.from_mem   = 1'b1;
        cmd_o.issue_read = !status_i.done;
        cmd_o.load_out   = status_i.done && out_free;
        cmd_o.load_hold  = status_i.done && !out_free;
      end
      ST_HOLD: begin
        cmd_o.load_out      = out_free;
        cmd_o.out_from_hold = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/ptw_datapath.sv
// Datapath of the page table walker: table memory, configuration, address
// generation, entry checks and result registers. Depends on ptw_pkg.
module ptw_datapath
  import ptw_pkg::*;
#(
  parameter int unsigned TableMemWords = TableMemWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [VaW-1:0]      virt_addr_i,
  input  logic [WidxW-1:0]    word_index_i,
  input  logic [PteW-1:0]     write_data_i,
  input  ptw_cmd_t            cmd_i,
  output ptw_status_t         status_o,
  output logic [PaW-1:0]      phys_addr_o,
  output logic                fault_o
);

  localparam int unsigned AddrW = $clog2(TableMemWords);
  localparam logic [63:0] MemWords64 = 64'(TableMemWords);

  // Table memory, one write and one registered read port
  logic [PteW-1:0] mem [TableMemWords];
  logic [PteW-1:0] rdata_q;

  logic               enabled_q;
  logic [RootW-1:0]   root_q;
  logic [VaUsedW-1:0] va_q;
  logic [LevelW-1:0]  level_q;

  logic [PaW-1:0] hold_pa_q;
  logic           hold_fault_q;
  logic [PaW-1:0] out_pa_q;
  logic           out_fault_q;

  logic [VaUsedW-1:0] va_cur;
  logic [LevelW-1:0]  next_level;
  logic [IdxW-1:0]    next_idx;
  logic [63:0]        next_word;
  logic               oob;
  logic               done;
  logic [PaW-1:0]     res_pa;
  logic               res_fault;
  logic [63:0]        wr_word;
  logic               wr_ok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      root_q    <= '0;
    end else if (cfg_we_i) begin
      case (ptw_cfg_e'(cfg_index_i))
        CFG_WALKER_ENABLED:  enabled_q <= cfg_data_i[0];
        CFG_ROOT_TABLE_BASE: root_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next entry address: table base from root or fetched entry, plus index
  assign va_cur     = cmd_i.from_mem ? va_q : virt_addr_i[VaUsedW-1:0];
  assign next_level = cmd_i.from_mem ? LevelW'(level_q + 2'd1) : '0;
  assign next_idx   = va_index(va_cur, next_level);

  always_comb begin
    if (cmd_i.from_mem) begin
      next_word = {3'b000, rdata_q[63:12], next_idx};
    end else begin
      next_word = 64'({root_q[RootW-1:12], next_idx});
    end
  end

  assign oob = (next_word >= MemWords64);

  // Evaluate the current step of the walk
  always_comb begin
    done      = 1'b0;
    res_pa    = '0;
    res_fault = 1'b1;
    if (!cmd_i.from_mem) begin
      if (!enabled_q || oob) begin
        done = 1'b1;
      end
    end else if (!rdata_q[PresentBit]) begin
      done = 1'b1;
    end else if ((level_q == LvlHuge) && rdata_q[HugeBit]) begin
      done      = 1'b1;
      res_pa    = {rdata_q[63:21], va_q[20:0]};
      res_fault = 1'b0;
    end else if (level_q == LvlLeaf) begin
      done      = 1'b1;
      res_pa    = {rdata_q[63:12], va_q[11:0]};
      res_fault = 1'b0;
    end else if (oob) begin
      done = 1'b1;
    end
  end

  assign status_o.done = done;

  // Write address check
  assign wr_word = 64'(word_index_i);
  assign wr_ok   = (wr_word < MemWords64);

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write && wr_ok) begin
      mem[wr_word[AddrW-1:0]] <= write_data_i;
    end
    if (cmd_i.issue_read) begin
      rdata_q <= mem[next_word[AddrW-1:0]];
    end
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (cmd_i.issue_read) begin
      level_q <= next_level;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      va_q <= virt_addr_i[VaUsedW-1:0];
    end
  end

  // Hold and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hold) begin
      hold_pa_q    <= res_pa;
      hold_fault_q <= res_fault;
    end
    if (cmd_i.load_out) begin
      out_pa_q    <= cmd_i.out_from_hold ? hold_pa_q : res_pa;
      out_fault_q <= cmd_i.out_from_hold ? hold_fault_q : res_fault;
    end
  end

  assign phys_addr_o = out_pa_q;
  assign fault_o     = out_fault_q;

endmodule
